### hdl/density_blur_grayscale_top_assert.svh
// ----------------------------------------------------------------------------
// density_blur_grayscale_top_assert.svh
// Assertion macros for the blur/grayscale RTL.
// ----------------------------------------------------------------------------
`ifndef DENSITY_BLUR_GRAYSCALE_TOP_ASSERT_SVH
`define DENSITY_BLUR_GRAYSCALE_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define DBG_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define DBG_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define DBG_ASSERT(lbl, prop, msg)
`define DBG_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

### hdl/dbg_pkg.sv
// ----------------------------------------------------------------------------
// dbg_pkg
// Widths, register map and types for the density blur/grayscale block.
// ----------------------------------------------------------------------------
package dbg_pkg;

	localparam int DENSITY_BITS = 20;
	localparam int SCALE_BITS   = 16;
	localparam int PROD_BITS    = DENSITY_BITS - 1 + SCALE_BITS;
	localparam int NORM_FRAC    = 24;
	localparam int NORM_BITS    = NORM_FRAC + 1;
	localparam int WEIGHT_BITS  = 8;
	localparam int KSUM_BITS    = 10;
	localparam int KSQ_BITS     = 2 * KSUM_BITS;
	localparam int TAP_BITS     = WEIGHT_BITS + NORM_BITS;
	localparam int ROW_BITS     = TAP_BITS + 2;
	localparam int COLP_BITS    = ROW_BITS + WEIGHT_BITS;
	localparam int NUM_BITS     = COLP_BITS + 2;
	localparam int DEN_BITS     = KSQ_BITS + NORM_FRAC;
	localparam int GRAY_BITS    = 8;
	localparam int X_BITS       = DEN_BITS + 1 + GRAY_BITS + 1;
	localparam int EDGE_BITS    = 4;
	localparam int TAPS         = 3;
	localparam int LANES        = TAPS * TAPS;
	localparam int CENTER_LANE  = LANES / 2;
	localparam int LATENCY      = 17;
	localparam int FIFO_DEPTH   = 32;
	localparam int PTR_BITS     = $clog2(FIFO_DEPTH);
	localparam int CNT_BITS     = PTR_BITS + 1;
	localparam int PADDR_BITS   = 5;
	localparam int PDATA_BITS   = 32;

	localparam logic [NORM_BITS-1:0] NORM_ONE = NORM_BITS'(1) << NORM_FRAC;
	localparam logic [GRAY_BITS-1:0] GRAY_MAX = '1;

	localparam logic [GRAY_BITS-1:0]   BLACK_RST = 8'd0;
	localparam logic                   BLUR_RST  = 1'b0;
	localparam logic [SCALE_BITS-1:0]  SCALE_RST = 16'd3277;
	localparam logic [WEIGHT_BITS-1:0] WB_RST    = 8'd1;
	localparam logic [WEIGHT_BITS-1:0] WM_RST    = 8'd2;
	localparam logic [WEIGHT_BITS-1:0] WA_RST    = 8'd1;
	localparam logic [KSUM_BITS-1:0]   KSUM_RST  = 10'd4;

	localparam int EDGE_LEFT   = 0;
	localparam int EDGE_RIGHT  = 1;
	localparam int EDGE_TOP    = 2;
	localparam int EDGE_BOTTOM = 3;

	typedef enum logic [2:0] {
		REG_BLACK_LEVEL   = 3'd0,
		REG_BLUR_ENABLE   = 3'd1,
		REG_VISUAL_SCALE  = 3'd2,
		REG_WEIGHT_BEFORE = 3'd3,
		REG_WEIGHT_MIDDLE = 3'd4,
		REG_WEIGHT_AFTER  = 3'd5,
		REG_KERNEL_SUM    = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [GRAY_BITS-1:0]   black_level;
		logic                   blur_enable;
		logic [SCALE_BITS-1:0]  visual_scale;
		logic [WEIGHT_BITS-1:0] weight_before;
		logic [WEIGHT_BITS-1:0] weight_middle;
		logic [WEIGHT_BITS-1:0] weight_after;
		logic [KSUM_BITS-1:0]   kernel_sum;
	} cfg_t;

	typedef logic [NORM_BITS-1:0] norm_t;
	typedef norm_t [LANES-1:0] norm_win_t;

endpackage

### hdl/dbg_in_if.sv
// ----------------------------------------------------------------------------
// dbg_in_if
// Window channel: nine density samples and the edge mask per beat.
// ----------------------------------------------------------------------------
interface dbg_in_if import dbg_pkg::*; ();
	logic                           valid;
	logic                           ready;
	logic signed [DENSITY_BITS-1:0] sample_up_left;
	logic signed [DENSITY_BITS-1:0] sample_up;
	logic signed [DENSITY_BITS-1:0] sample_up_right;
	logic signed [DENSITY_BITS-1:0] sample_left;
	logic signed [DENSITY_BITS-1:0] sample_center;
	logic signed [DENSITY_BITS-1:0] sample_right;
	logic signed [DENSITY_BITS-1:0] sample_down_left;
	logic signed [DENSITY_BITS-1:0] sample_down;
	logic signed [DENSITY_BITS-1:0] sample_down_right;
	logic [EDGE_BITS-1:0]           edge_mask;

	modport source (
		output valid, sample_up_left, sample_up, sample_up_right, sample_left,
		       sample_center, sample_right, sample_down_left, sample_down,
		       sample_down_right, edge_mask,
		input  ready
	);
	modport sink (
		input  valid, sample_up_left, sample_up, sample_up_right, sample_left,
		       sample_center, sample_right, sample_down_left, sample_down,
		       sample_down_right, edge_mask,
		output ready
	);
endinterface

### hdl/dbg_out_if.sv
// ----------------------------------------------------------------------------
// dbg_out_if
// Pixel channel: one gray level per beat.
// ----------------------------------------------------------------------------
interface dbg_out_if import dbg_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [GRAY_BITS-1:0] gray_level;

	modport source (output valid, gray_level, input ready);
	modport sink (input valid, gray_level, output ready);
endinterface

### hdl/dbg_cfg.sv
// ----------------------------------------------------------------------------
// dbg_cfg
// APB register file for level, scale, blur and kernel settings.
// ----------------------------------------------------------------------------
module dbg_cfg import dbg_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [PADDR_BITS-1:0] paddr,
	input  logic [PDATA_BITS-1:0] pwdata,
	output logic [PDATA_BITS-1:0] prdata,
	output logic                  pready,
	output cfg_t                  cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[PADDR_BITS-1:2]);
	assign wr_en  = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.black_level   <= BLACK_RST;
			cfg_q.blur_enable   <= BLUR_RST;
			cfg_q.visual_scale  <= SCALE_RST;
			cfg_q.weight_before <= WB_RST;
			cfg_q.weight_middle <= WM_RST;
			cfg_q.weight_after  <= WA_RST;
			cfg_q.kernel_sum    <= KSUM_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_BLACK_LEVEL:   cfg_q.black_level   <= pwdata[GRAY_BITS-1:0];
				REG_BLUR_ENABLE:   cfg_q.blur_enable   <= pwdata[0];
				REG_VISUAL_SCALE:  cfg_q.visual_scale  <= pwdata[SCALE_BITS-1:0];
				REG_WEIGHT_BEFORE: cfg_q.weight_before <= pwdata[WEIGHT_BITS-1:0];
				REG_WEIGHT_MIDDLE: cfg_q.weight_middle <= pwdata[WEIGHT_BITS-1:0];
				REG_WEIGHT_AFTER:  cfg_q.weight_after  <= pwdata[WEIGHT_BITS-1:0];
				REG_KERNEL_SUM:    cfg_q.kernel_sum    <= pwdata[KSUM_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_BLACK_LEVEL:   prdata = PDATA_BITS'(cfg_q.black_level);
			REG_BLUR_ENABLE:   prdata = PDATA_BITS'(cfg_q.blur_enable);
			REG_VISUAL_SCALE:  prdata = PDATA_BITS'(cfg_q.visual_scale);
			REG_WEIGHT_BEFORE: prdata = PDATA_BITS'(cfg_q.weight_before);
			REG_WEIGHT_MIDDLE: prdata = PDATA_BITS'(cfg_q.weight_middle);
			REG_WEIGHT_AFTER:  prdata = PDATA_BITS'(cfg_q.weight_after);
			REG_KERNEL_SUM:    prdata = PDATA_BITS'(cfg_q.kernel_sum);
			default:           prdata = '0;
		endcase
	end

endmodule

### hdl/dbg_lane.sv
// ----------------------------------------------------------------------------
// dbg_lane
// One sample lane: scale by visual_scale, clamp to [0, 1.0] in Q.24.
// ----------------------------------------------------------------------------
module dbg_lane import dbg_pkg::*; (
	input  logic                           clk,
	input  logic signed [DENSITY_BITS-1:0] sample,
	input  logic [SCALE_BITS-1:0]          scale,
	output norm_t                          norm
);

	logic                 pos_s1;
	logic [PROD_BITS-1:0] prod_s1;
	norm_t                norm_s2;

	always_ff @(posedge clk) begin
		pos_s1  <= !sample[DENSITY_BITS-1] && (|sample);
		prod_s1 <= PROD_BITS'(sample[DENSITY_BITS-2:0]) * PROD_BITS'(scale);
	end

	always_ff @(posedge clk) begin
		if (!pos_s1) begin
			norm_s2 <= '0;
		end else if (prod_s1 > PROD_BITS'(NORM_ONE)) begin
			norm_s2 <= NORM_ONE;
		end else begin
			norm_s2 <= prod_s1[NORM_BITS-1:0];
		end
	end

	assign norm = norm_s2;

endmodule

### hdl/dbg_merge.sv
// ----------------------------------------------------------------------------
// dbg_merge
// Edge replacement and separable 3-tap blur over the nine lane results.
// Produces the clamped numerator and the denominator of the blurred value, or of the center value when blur is off.
// ----------------------------------------------------------------------------
module dbg_merge import dbg_pkg::*; (
	input  logic                 clk,
	input  norm_win_t            norm,
	input  logic [EDGE_BITS-1:0] edges,
	input  cfg_t                 cfg,
	output logic [DEN_BITS-1:0]  num,
	output logic [DEN_BITS-1:0]  den
);

	logic [WEIGHT_BITS-1:0] wt [TAPS];
	norm_t                  hz [TAPS][TAPS];
	norm_t                  vt [TAPS][TAPS];
	logic [KSUM_BITS-1:0]   ks;
	logic [KSQ_BITS-1:0]    ksq_q;

	logic [TAP_BITS-1:0]  tap_s3 [TAPS][TAPS];
	norm_t                ctr_s3, ctr_s4, ctr_s5;
	logic [ROW_BITS-1:0]  row_s4 [TAPS];
	logic [COLP_BITS-1:0] colp_s5 [TAPS];
	logic [NUM_BITS-1:0]  num_s6;
	logic [DEN_BITS-1:0]  den_s6;
	logic [DEN_BITS-1:0]  num_s7, den_s7;

	assign wt[0] = cfg.weight_before;
	assign wt[1] = cfg.weight_middle;
	assign wt[2] = cfg.weight_after;
	assign ks    = (cfg.kernel_sum == '0) ? KSUM_BITS'(1) : cfg.kernel_sum;

	// columns first, then rows from the already replaced columns
	always_comb begin
		for (int r = 0; r < TAPS; r++) begin
			for (int c = 0; c < TAPS; c++) begin
				if ((c == 0 && edges[EDGE_LEFT]) || (c == TAPS-1 && edges[EDGE_RIGHT])) begin
					hz[r][c] = norm[r*TAPS + 1];
				end else begin
					hz[r][c] = norm[r*TAPS + c];
				end
			end
		end
		for (int r = 0; r < TAPS; r++) begin
			for (int c = 0; c < TAPS; c++) begin
				if ((r == 0 && edges[EDGE_TOP]) || (r == TAPS-1 && edges[EDGE_BOTTOM])) begin
					vt[r][c] = hz[1][c];
				end else begin
					vt[r][c] = hz[r][c];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		ksq_q <= KSQ_BITS'(ks) * KSQ_BITS'(ks);
	end

	always_ff @(posedge clk) begin
		for (int r = 0; r < TAPS; r++) begin
			for (int c = 0; c < TAPS; c++) begin
				tap_s3[r][c] <= TAP_BITS'(wt[c]) * TAP_BITS'(vt[r][c]);
			end
		end
		ctr_s3 <= norm[CENTER_LANE];
	end

	always_ff @(posedge clk) begin
		for (int r = 0; r < TAPS; r++) begin
			row_s4[r] <= ROW_BITS'(tap_s3[r][0]) + ROW_BITS'(tap_s3[r][1])
			           + ROW_BITS'(tap_s3[r][2]);
		end
		ctr_s4 <= ctr_s3;
	end

	always_ff @(posedge clk) begin
		for (int r = 0; r < TAPS; r++) begin
			colp_s5[r] <= COLP_BITS'(wt[r]) * COLP_BITS'(row_s4[r]);
		end
		ctr_s5 <= ctr_s4;
	end

	always_ff @(posedge clk) begin
		if (cfg.blur_enable) begin
			num_s6 <= NUM_BITS'(colp_s5[0]) + NUM_BITS'(colp_s5[1]) + NUM_BITS'(colp_s5[2]);
			den_s6 <= DEN_BITS'(ksq_q) << NORM_FRAC;
		end else begin
			num_s6 <= NUM_BITS'(ctr_s5);
			den_s6 <= DEN_BITS'(NORM_ONE);
		end
	end

	always_ff @(posedge clk) begin
		if (num_s6 > NUM_BITS'(den_s6)) begin
			num_s7 <= den_s6;
		end else begin
			num_s7 <= num_s6[DEN_BITS-1:0];
		end
		den_s7 <= den_s6;
	end

	assign num = num_s7;
	assign den = den_s7;

endmodule

### hdl/dbg_map.sv
// ----------------------------------------------------------------------------
// dbg_map
// Gray mapping: black + round-half-up(num * (255 - black) / den), with a
// pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module dbg_map import dbg_pkg::*; (
	input  logic                 clk,
	input  logic [DEN_BITS-1:0]  num,
	input  logic [DEN_BITS-1:0]  den,
	input  cfg_t                 cfg,
	output logic [GRAY_BITS-1:0] gray
);

	logic [GRAY_BITS-1:0] span;
	logic [X_BITS-1:0]    rem_s [GRAY_BITS];
	logic [DEN_BITS:0]    dv_s  [GRAY_BITS];
	logic [GRAY_BITS-1:0] quo_s [GRAY_BITS+1];
	logic [GRAY_BITS-1:0] gray_s17;

	assign span = GRAY_MAX - cfg.black_level;

	// dividend 2*num*span + den over divisor 2*den
	always_ff @(posedge clk) begin
		rem_s[0] <= ((X_BITS'(num) << 1) * X_BITS'(span)) + X_BITS'(den);
		dv_s[0]  <= {den, 1'b0};
		quo_s[0] <= '0;
	end

	for (genvar i = 0; i < GRAY_BITS; i++) begin : g_div
		logic [X_BITS-1:0] trial;
		logic              ge;

		assign trial = X_BITS'(dv_s[i]) << (GRAY_BITS - 1 - i);
		assign ge    = rem_s[i] >= trial;

		always_ff @(posedge clk) begin
			quo_s[i+1] <= {quo_s[i][GRAY_BITS-2:0], ge};
		end

		if (i < GRAY_BITS - 1) begin : g_carry
			always_ff @(posedge clk) begin
				rem_s[i+1] <= ge ? (rem_s[i] - trial) : rem_s[i];
				dv_s[i+1]  <= dv_s[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		gray_s17 <= cfg.black_level + quo_s[GRAY_BITS];
	end

	assign gray = gray_s17;

endmodule

### hdl/density_blur_grayscale_top.sv
// ----------------------------------------------------------------------------
// density_blur_grayscale_top
// Density window to gray pixel: scale/clamp, optional 3x3 blur, gray map.
//
// window: one beat carries a 3x3 window of signed Q12.8 densities plus the
// edge mask. pixel: one beat carries the gray level of the center cell,
// in the order the windows came in. APB port holds the level, blur and
// kernel registers; write them only while no pixel is pending.
// Throughput: one window per clock while credit remains. A window beat
// reaches the pixel side through nine scale lanes, the blur tree, the
// 8-stage divider and the result queue.
// Results drop into a 32-entry queue. The window side counts beats in
// flight plus queued and drops ready when 32 are outstanding, so a stalled
// receiver backs the pipeline up without losing beats; a window is still
// taken while a finished pixel waits, as long as credit remains.
// Reset: registers return to defaults, pipeline and queue are emptied.
// ----------------------------------------------------------------------------
`include "density_blur_grayscale_top_assert.svh"

module density_blur_grayscale_top import dbg_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	dbg_in_if.sink                window,
	dbg_out_if.source             pixel,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [PADDR_BITS-1:0] paddr,
	input  logic [PDATA_BITS-1:0] pwdata,
	output logic [PDATA_BITS-1:0] prdata,
	output logic                  pready
);

	cfg_t                           cfg;
	logic signed [DENSITY_BITS-1:0] samp [LANES];
	norm_win_t                      norm;
	logic [EDGE_BITS-1:0]           edge_s1, edge_s2;
	logic [DEN_BITS-1:0]            num, den;
	logic [GRAY_BITS-1:0]           gray;

	logic                           acc, pop;
	logic [LATENCY-1:0]             vld_q;
	logic [GRAY_BITS-1:0]           fifo_q [FIFO_DEPTH];
	logic [PTR_BITS-1:0]            wr_ptr_q, rd_ptr_q;
	logic [CNT_BITS-1:0]            fill_q, outst_q;
	logic                           push;

	dbg_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	assign samp[0] = window.sample_up_left;
	assign samp[1] = window.sample_up;
	assign samp[2] = window.sample_up_right;
	assign samp[3] = window.sample_left;
	assign samp[4] = window.sample_center;
	assign samp[5] = window.sample_right;
	assign samp[6] = window.sample_down_left;
	assign samp[7] = window.sample_down;
	assign samp[8] = window.sample_down_right;

	for (genvar i = 0; i < LANES; i++) begin : g_lane
		dbg_lane u_lane (
			.clk   (clk),
			.sample(samp[i]),
			.scale (cfg.visual_scale),
			.norm  (norm[i])
		);
	end

	always_ff @(posedge clk) begin
		edge_s1 <= window.edge_mask;
		edge_s2 <= edge_s1;
	end

	dbg_merge u_merge (
		.clk  (clk),
		.norm (norm),
		.edges(edge_s2),
		.cfg  (cfg),
		.num  (num),
		.den  (den)
	);

	dbg_map u_map (
		.clk (clk),
		.num (num),
		.den (den),
		.cfg (cfg),
		.gray(gray)
	);

	assign window.ready = outst_q < CNT_BITS'(FIFO_DEPTH);
	assign acc          = window.valid & window.ready;
	assign pop          = pixel.valid & pixel.ready;
	assign push         = vld_q[LATENCY-1];

	assign pixel.valid      = fill_q != '0;
	assign pixel.gray_level = fifo_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
			outst_q  <= '0;
		end else begin
			vld_q <= {vld_q[LATENCY-2:0], acc};
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_BITS'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_BITS'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + CNT_BITS'(1);
			end else if (!push && pop) begin
				fill_q <= fill_q - CNT_BITS'(1);
			end
			if (acc && !pop) begin
				outst_q <= outst_q + CNT_BITS'(1);
			end else if (!acc && pop) begin
				outst_q <= outst_q - CNT_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= gray;
		end
	end

	`DBG_ASSERT(a_credit_bound, outst_q <= CNT_BITS'(FIFO_DEPTH), "outstanding beats exceed queue depth")
	`DBG_ASSERT(a_credit_sum, ($countones(vld_q) + int'(fill_q)) == int'(outst_q), "credit count lost track of beats")
	`DBG_ASSERT_NXT(a_credit_inc, acc && !pop, outst_q == $past(outst_q) + CNT_BITS'(1), "accepted window not counted")
	`DBG_ASSERT(a_gray_floor, !pixel.valid || (pixel.gray_level >= cfg.black_level), "gray level below black level")

endmodule

### test/dbg_checker.sv
// ----------------------------------------------------------------------------
// dbg_checker
// Watches the window, pixel and APB ports of the blur/grayscale block and
// checks every pixel beat.
// Keeps its own copy of the registers from the APB writes it sees. For each
// window beat it computes the gray level and queues it. Each pixel beat is
// compared with the oldest queued level. The number of queued levels and
// the failure count go back to the testbench top.
// ----------------------------------------------------------------------------
module dbg_checker import dbg_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	dbg_in_if                     window,
	dbg_out_if                    pixel,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic                  pready,
	input  logic [PADDR_BITS-1:0] paddr,
	input  logic [PDATA_BITS-1:0] pwdata,
	output int unsigned           outstanding,
	output int unsigned           failures
);
	timeunit 1ns;
	timeprecision 1ps;

	cfg_t                 regs;
	logic [GRAY_BITS-1:0] gray_due [$];
	int unsigned          fail_cnt = 0;

	// sample * scale, clamped to [0, 1.0] in Q.24
	function automatic bit [63:0] brightness(input logic signed [DENSITY_BITS-1:0] s,
			input logic [SCALE_BITS-1:0] scale);
		longint prod;
		if (s <= 0)
			return 64'd0;
		prod = longint'(s) * longint'(scale);
		if (prod > (longint'(1) << NORM_FRAC))
			return 64'd1 << NORM_FRAC;
		return prod;
	endfunction

	function automatic logic [GRAY_BITS-1:0] predict_gray(input cfg_t c,
			input logic [LANES-1:0][DENSITY_BITS-1:0] win, input logic [EDGE_BITS-1:0] em);
		bit [63:0] lvl [3][3];
		bit [63:0] w [3];
		bit [63:0] num;
		bit [63:0] den;
		bit [63:0] ks;
		bit [63:0] blk;
		bit [63:0] row_acc;
		bit [63:0] total;
		for (int r = 0; r < TAPS; r++)
			for (int k = 0; k < TAPS; k++)
				lvl[r][k] = brightness(signed'(win[r * TAPS + k]), c.visual_scale);
		if (c.blur_enable) begin
			w[0] = 64'(c.weight_before);
			w[1] = 64'(c.weight_middle);
			w[2] = 64'(c.weight_after);
			ks = (c.kernel_sum == 0) ? 64'd1 : 64'(c.kernel_sum);
			for (int r = 0; r < TAPS; r++) begin
				if (em[EDGE_LEFT])
					lvl[r][0] = lvl[r][1];
				if (em[EDGE_RIGHT])
					lvl[r][2] = lvl[r][1];
			end
			for (int k = 0; k < TAPS; k++) begin
				if (em[EDGE_TOP])
					lvl[0][k] = lvl[1][k];
				if (em[EDGE_BOTTOM])
					lvl[2][k] = lvl[1][k];
			end
			num = 0;
			for (int r = 0; r < TAPS; r++) begin
				row_acc = 0;
				for (int k = 0; k < TAPS; k++)
					row_acc += w[k] * lvl[r][k];
				num += w[r] * row_acc;
			end
			den = (ks * ks) << NORM_FRAC;
		end else begin
			num = lvl[1][1];
			den = 64'd1 << NORM_FRAC;
		end
		if (num > den)
			num = den;
		blk = 64'(c.black_level);
		total = 2 * blk * den + 2 * num * (255 - blk) + den;
		return GRAY_BITS'(total / (2 * den));
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [GRAY_BITS-1:0] want;
		if (!arst_n) begin
			regs <= '{black_level: BLACK_RST, blur_enable: BLUR_RST, visual_scale: SCALE_RST,
				weight_before: WB_RST, weight_middle: WM_RST, weight_after: WA_RST,
				kernel_sum: KSUM_RST};
			gray_due.delete();
			outstanding <= 0;
			failures <= fail_cnt;
		end else begin
			if (window.valid && window.ready)
				gray_due.push_back(predict_gray(regs,
					{window.sample_down_right, window.sample_down, window.sample_down_left,
					 window.sample_right, window.sample_center, window.sample_left,
					 window.sample_up_right, window.sample_up, window.sample_up_left},
					window.edge_mask));
			if (pixel.valid && pixel.ready) begin
				if (gray_due.size() == 0) begin
					fail_cnt++;
					if (fail_cnt <= 10)
						$display("%0t: pixel beat %0d with no window pending",
							$realtime, pixel.gray_level);
				end else begin
					want = gray_due.pop_front();
					if (pixel.gray_level !== want) begin
						fail_cnt++;
						if (fail_cnt <= 10)
							$display("%0t: gray_level expected %0d, got %0d",
								$realtime, want, pixel.gray_level);
					end
				end
			end
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[PADDR_BITS-1:2]))
					REG_BLACK_LEVEL:   regs.black_level   <= pwdata[GRAY_BITS-1:0];
					REG_BLUR_ENABLE:   regs.blur_enable   <= pwdata[0];
					REG_VISUAL_SCALE:  regs.visual_scale  <= pwdata[SCALE_BITS-1:0];
					REG_WEIGHT_BEFORE: regs.weight_before <= pwdata[WEIGHT_BITS-1:0];
					REG_WEIGHT_MIDDLE: regs.weight_middle <= pwdata[WEIGHT_BITS-1:0];
					REG_WEIGHT_AFTER:  regs.weight_after  <= pwdata[WEIGHT_BITS-1:0];
					REG_KERNEL_SUM:    regs.kernel_sum    <= pwdata[KSUM_BITS-1:0];
					default: ;
				endcase
			end
			outstanding <= gray_due.size();
			failures <= fail_cnt;
		end
	end

endmodule

### test/tb_density_blur_grayscale_top.sv
// ----------------------------------------------------------------------------
// tb_density_blur_grayscale_top
// Stimulus and verdict for the density blur/grayscale block.
// A directed pass covers sample extremes, blur off and every edge mask, then
// random windows run under a series of register settings, extremes included.
// Both channels idle in random bursts except in the last phase. Registers
// are only written once every queued pixel has come back.
// ----------------------------------------------------------------------------
module tb_density_blur_grayscale_top import dbg_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 500000;
	localparam int PHASES      = 9;
	localparam int PHASE_BEATS = 112;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [PADDR_BITS-1:0] paddr;
	logic [PDATA_BITS-1:0] pwdata;
	logic [PDATA_BITS-1:0] prdata;
	logic                  pready;
	int unsigned           outstanding;
	int unsigned           failures;
	int unsigned           cycle_cnt = 0;
	bit                    calm = 1'b0;
	logic [SCALE_BITS-1:0] cur_scale = SCALE_RST;
	int                    center_probe [8] = '{0, -1, -524288, 524287, 5120, 5119, 1, 2560};

	dbg_in_if  win_ch ();
	dbg_out_if pix_ch ();

	density_blur_grayscale_top u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.window  (win_ch),
		.pixel   (pix_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	dbg_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.window      (win_ch),
		.pixel       (pix_ch),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.pready      (pready),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.outstanding (outstanding),
		.failures    (failures)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	function automatic logic [PDATA_BITS-1:0] junk_above(input int n);
		return $urandom & ~((32'd1 << n) - 1);
	endfunction

	// mostly densities that land inside the useful brightness range
	function automatic logic [DENSITY_BITS-1:0] draw_density();
		int lim;
		lim = (cur_scale == 0) ? 524287 : (1 << NORM_FRAC) / int'(cur_scale) + 4;
		if (lim > 524287)
			lim = 524287;
		case ($urandom_range(0, 9))
			0: return DENSITY_BITS'($urandom);
			1: begin
				case ($urandom_range(0, 4))
					0: return DENSITY_BITS'(-524288);
					1: return DENSITY_BITS'(524287);
					2: return '0;
					3: return '1;
					default: return DENSITY_BITS'(1);
				endcase
			end
			2: return DENSITY_BITS'(-$urandom_range(1, lim));
			default: return DENSITY_BITS'($urandom_range(0, lim));
		endcase
	endfunction

	function automatic cfg_t random_cfg();
		cfg_t c;
		c.black_level = GRAY_BITS'($urandom_range(0, 255));
		c.blur_enable = ($urandom_range(0, 3) != 0);
		c.visual_scale = $urandom_range(0, 1) ? SCALE_BITS'($urandom_range(0, 65535))
			: SCALE_BITS'($urandom_range(100, 8000));
		c.weight_before = WEIGHT_BITS'($urandom_range(0, 255));
		c.weight_middle = WEIGHT_BITS'($urandom_range(0, 255));
		c.weight_after = WEIGHT_BITS'($urandom_range(0, 255));
		if ($urandom_range(0, 3) == 0)
			c.kernel_sum = KSUM_BITS'($urandom_range(0, 1023));
		else
			c.kernel_sum = KSUM_BITS'(c.weight_before) + KSUM_BITS'(c.weight_middle)
				+ KSUM_BITS'(c.weight_after);
		if (c.kernel_sum == 0)
			c.kernel_sum = 1;
		return c;
	endfunction

	task automatic apb_write(input reg_idx_t idx, input logic [PDATA_BITS-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic program_regs(input cfg_t c);
		apb_write(REG_BLACK_LEVEL, junk_above(GRAY_BITS) | PDATA_BITS'(c.black_level));
		apb_write(REG_BLUR_ENABLE, junk_above(1) | PDATA_BITS'(c.blur_enable));
		apb_write(REG_VISUAL_SCALE, junk_above(SCALE_BITS) | PDATA_BITS'(c.visual_scale));
		apb_write(REG_WEIGHT_BEFORE, junk_above(WEIGHT_BITS) | PDATA_BITS'(c.weight_before));
		apb_write(REG_WEIGHT_MIDDLE, junk_above(WEIGHT_BITS) | PDATA_BITS'(c.weight_middle));
		apb_write(REG_WEIGHT_AFTER, junk_above(WEIGHT_BITS) | PDATA_BITS'(c.weight_after));
		apb_write(REG_KERNEL_SUM, junk_above(KSUM_BITS) | PDATA_BITS'(c.kernel_sum));
		cur_scale = c.visual_scale;
	endtask

	task automatic send_window(input logic [LANES-1:0][DENSITY_BITS-1:0] s,
			input logic [EDGE_BITS-1:0] em);
		win_ch.valid <= 1'b1;
		win_ch.sample_up_left <= s[0];
		win_ch.sample_up <= s[1];
		win_ch.sample_up_right <= s[2];
		win_ch.sample_left <= s[3];
		win_ch.sample_center <= s[4];
		win_ch.sample_right <= s[5];
		win_ch.sample_down_left <= s[6];
		win_ch.sample_down <= s[7];
		win_ch.sample_down_right <= s[8];
		win_ch.edge_mask <= em;
		@(posedge clk);
		while (!win_ch.ready)
			@(posedge clk);
		if (!calm && $urandom_range(0, 5) == 0) begin
			win_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 17))
				@(posedge clk);
		end
	endtask

	// stop sending and wait for every queued pixel
	task automatic drain();
		win_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	initial begin
		pix_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (!calm && $urandom_range(0, 3) == 0) begin
				pix_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 17))
					@(posedge clk);
			end
			pix_ch.ready <= 1'b1;
			repeat ($urandom_range(1, 40))
				@(posedge clk);
		end
	end

	initial begin
		cfg_t                                c;
		logic [LANES-1:0][DENSITY_BITS-1:0] s;
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		win_ch.valid <= 1'b0;
		win_ch.sample_up_left <= '0;
		win_ch.sample_up <= '0;
		win_ch.sample_up_right <= '0;
		win_ch.sample_left <= '0;
		win_ch.sample_center <= '0;
		win_ch.sample_right <= '0;
		win_ch.sample_down_left <= '0;
		win_ch.sample_down <= '0;
		win_ch.sample_down_right <= '0;
		win_ch.edge_mask <= '0;
		repeat (12)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings, blur off: center sample only, neighbors and mask ignored
		for (int i = 0; i < 8; i++) begin
			for (int k = 0; k < LANES; k++)
				s[k] = DENSITY_BITS'($urandom);
			s[CENTER_LANE] = DENSITY_BITS'(center_probe[i]);
			send_window(s, EDGE_BITS'($urandom_range(0, 15)));
		end
		drain();

		// default kernel with blur on, every edge mask
		c = '{black_level: BLACK_RST, blur_enable: 1'b1, visual_scale: SCALE_RST,
			weight_before: WB_RST, weight_middle: WM_RST, weight_after: WA_RST,
			kernel_sum: KSUM_RST};
		program_regs(c);
		for (int em = 0; em < 16; em++) begin
			for (int k = 0; k < LANES; k++)
				s[k] = draw_density();
			send_window(s, EDGE_BITS'(em));
		end

		for (int p = 0; p < PHASES; p++) begin
			drain();
			case (p)
				1: c = '{black_level: 8'd255, blur_enable: 1'b1, visual_scale: 16'hFFFF,
					weight_before: 8'd255, weight_middle: 8'd255, weight_after: 8'd255,
					kernel_sum: 10'd765};
				3: c = '{black_level: 8'd0, blur_enable: 1'b1, visual_scale: 16'd1,
					weight_before: 8'd0, weight_middle: 8'd0, weight_after: 8'd0,
					kernel_sum: 10'd1023};
				5: c = '{black_level: 8'd128, blur_enable: 1'b1, visual_scale: SCALE_RST,
					weight_before: 8'd200, weight_middle: 8'd255, weight_after: 8'd17,
					kernel_sum: 10'd0};
				7: c = '{black_level: 8'd0, blur_enable: 1'b0, visual_scale: 16'd0,
					weight_before: 8'd1, weight_middle: 8'd1, weight_after: 8'd1,
					kernel_sum: 10'd3};
				default: c = random_cfg();
			endcase
			program_regs(c);
			if (p == PHASES - 1)
				calm = 1'b1;
			for (int n = 0; n < PHASE_BEATS; n++) begin
				if (p == 4 && n == PHASE_BEATS / 2)
					drain();
				for (int k = 0; k < LANES; k++)
					s[k] = draw_density();
				send_window(s, EDGE_BITS'($urandom_range(0, 15)));
			end
		end
		drain();
		repeat (LATENCY + 8)
			@(posedge clk);

		if (failures == 0 && outstanding == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
